// File: rtl/gdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gdr_pkg;

	localparam int unsigned DIFF_W = 14;  // 100*|r| - 128*p, at most 12800
	localparam int unsigned DIV_W  = 7;   // 100 - p, 1..100
	localparam int unsigned CFG_W  = 7;

	localparam logic [6:0] DZ_MAX       = 7'd99;
	localparam logic [6:0] STRENGTH_MAX = 7'd100;
	localparam logic [7:0] MOTOR_TAG    = 8'h11;

	typedef enum logic [0:0] {
		REG_DEADZONE = 1'b0,
		REG_STRENGTH = 1'b1
	} gdr_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START_X,
		ST_WAIT_X,
		ST_START_Y,
		ST_WAIT_Y,
		ST_FIN
	} gdr_state_t;

	typedef struct packed {
		logic              pad_present;
		logic [15:0]       raw_buttons;
		logic signed [7:0] joy_x_raw;
		logic signed [7:0] joy_y_raw;
		logic [7:0]        left_trigger;
		logic [7:0]        right_trigger;
		logic              rumble_request;
		logic              vibrator_present;
	} gdr_in_t;

	typedef struct packed {
		logic               connected;
		logic [15:0]        mapped_buttons;
		logic signed [15:0] stick_x;
		logic signed [15:0] stick_y;
		logic [7:0]         left_level;
		logic [7:0]         right_level;
		logic               motor_send;
		logic [31:0]        motor_word;
	} gdr_out_t;

	typedef struct packed {
		logic              start;
		logic [DIFF_W-1:0] diff;
		logic [DIV_W-1:0]  divisor;
	} gdr_div_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} gdr_div_sts_t;

	function automatic logic [15:0] remap(input logic [15:0] b, input logic [7:0] lt,
		input logic [7:0] rt);
		logic [15:0] m;
		m     = '0;
		m[15] = b[2];   // A
		m[14] = b[1];   // B
		m[13] = lt[7];  // left trigger past half travel
		m[12] = b[3];   // Start
		m[11] = b[4];   // dpad up
		m[10] = b[5];   // dpad down
		m[9]  = b[6];   // dpad left
		m[8]  = b[7];   // dpad right
		m[4]  = rt[7];  // right trigger past half travel
		m[2]  = b[10];  // X
		m[1]  = b[9];   // Y
		return m;
	endfunction

	// intensity = 1 + (s*14 + 50)/100, s clamped to 100; counted by thresholds
	function automatic logic [3:0] motor_level(input logic [6:0] strength);
		logic [6:0]  s;
		logic [10:0] v;
		logic [3:0]  k;
		s = (strength > STRENGTH_MAX) ? STRENGTH_MAX : strength;
		v = 11'(s) * 11'd14 + 11'd50;
		k = 4'd1;
		for (int i = 1; i <= 14; i++) begin
			if (v >= 11'(100 * i))
				k = k + 4'd1;
		end
		return k;
	endfunction

endpackage

`default_nettype wire

// File: rtl/gdr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gdr_in_if;
	logic             valid;
	logic             ready;
	gdr_pkg::gdr_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gdr_out_if;
	logic              valid;
	logic              ready;
	gdr_pkg::gdr_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/gdr_axis_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// quot = (diff << (FRAC-7)) / divisor, equal to (diff << FRAC) / (128*divisor).
module gdr_axis_div #(
	parameter int unsigned AXIS_FRAC_BITS = 15
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  gdr_pkg::gdr_div_cmd_t     cmd,
	output gdr_pkg::gdr_div_sts_t     sts,
	output logic [AXIS_FRAC_BITS+6:0] quot
);

	localparam int unsigned NW = AXIS_FRAC_BITS + 7;
	localparam int unsigned SH = AXIS_FRAC_BITS - 7;
	localparam int unsigned CW = $clog2(NW + 1);

	logic [NW-1:0]               num_q;
	logic [NW-1:0]               quot_q;
	logic [gdr_pkg::DIV_W-1:0]   rem_q;
	logic [gdr_pkg::DIV_W-1:0]   den_q;
	logic [CW-1:0]               cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [gdr_pkg::DIV_W:0]     trial;
	logic                        ge;
	logic [gdr_pkg::DIV_W:0]     rem_sub;

	assign trial   = {rem_q, num_q[NW-1]};
	assign ge      = trial >= {1'b0, den_q};
	assign rem_sub = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			num_q  <= NW'(cmd.diff) << SH;
			den_q  <= cmd.divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[NW-2:0], 1'b0};
			rem_q  <= ge ? rem_sub[gdr_pkg::DIV_W-1:0] : trial[gdr_pkg::DIV_W-1:0];
			quot_q <= {quot_q[NW-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = quot_q;

endmodule

`default_nettype wire

// File: rtl/gamepad_deadzone_remapper.sv
`timescale 1ns / 1ps
`default_nettype none

// Gamepad poll remapper.
// pad_in (sink): one pad poll per transfer. pad_out (source): one result per poll.
// cfg_we/cfg_index/cfg_wdata: register 0 is the stick deadzone in percent
// (reset 15, values above 99 act as 99), register 1 the rumble strength in
// percent (reset 100, values above 100 act as 100). Write only while idle.
// Buttons are remapped and triggers at half travel or more set buttons; each
// stick axis (vertical inverted) passes an axial deadzone and is rescaled to
// signed Q1.(AXIS_FRAC_BITS), saturating to 16 bits. A change of the rumble
// request from a present pad emits a motor word if a vibration unit is attached.
// The single bit-serial divider runs the horizontal axis and then the vertical
// axis. One poll is in work at a time; the next is taken once the previous
// result sits in the output register.
// A stalled receiver holds the output register; a finished poll waits in the
// final step until the register frees, and no new poll is taken meanwhile.
// Reset: registers return to their defaults, motor state and held trigger
// levels clear, output empty, input ready.
module gamepad_deadzone_remapper #(
	parameter int unsigned AXIS_FRAC_BITS = 15
) (
	input  wire                         clk,
	input  wire                         arst_n,
	gdr_in_if.sink                      pad_in,
	gdr_out_if.source                   pad_out,
	input  wire                         cfg_we,
	input  wire                         cfg_index,
	input  wire [gdr_pkg::CFG_W-1:0]    cfg_wdata
);

	localparam int unsigned NW    = AXIS_FRAC_BITS + 7;
	localparam int unsigned EXT_W = (NW > 17) ? NW : 17;

	// configuration
	logic [gdr_pkg::CFG_W-1:0] deadzone_q;
	logic [gdr_pkg::CFG_W-1:0] strength_q;

	// control state
	gdr_pkg::gdr_state_t state_q, state_d;
	logic                motor_on_q;
	logic [7:0]          left_hold_q;
	logic [7:0]          right_hold_q;
	logic                out_valid_q;

	// poll in work
	logic              conn_q;
	logic [15:0]       btn_q;
	logic signed [7:0] jx_q;
	logic signed [7:0] jy_q;
	logic              send_q;
	logic [31:0]       word_q;
	logic [15:0]       sx_q;

	gdr_pkg::gdr_out_t out_q;

	logic in_xfer;
	logic axis_y;
	logic load_out;
	logic div_start;

	gdr_pkg::gdr_div_cmd_t div_cmd;
	gdr_pkg::gdr_div_sts_t div_sts;
	logic [NW-1:0]         quot;

	// axis operand path
	logic [6:0]        dz;
	logic signed [7:0] raw;
	logic [7:0]        mag_a;
	logic [13:0]       a100;
	logic [13:0]       p128;
	logic              below;
	logic              neg;
	logic [EXT_W-1:0]  mag_e;
	logic [15:0]       mag_neg;
	logic [15:0]       axis_val;

	assign in_xfer = pad_in.valid && pad_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q <= 7'd15;
			strength_q <= 7'd100;
		end else if (cfg_we) begin
			case (gdr_pkg::gdr_reg_t'(cfg_index))
				gdr_pkg::REG_DEADZONE: deadzone_q <= cfg_wdata;
				gdr_pkg::REG_STRENGTH: strength_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= gdr_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gdr_pkg::ST_IDLE:    if (pad_in.valid) state_d = gdr_pkg::ST_START_X;
			gdr_pkg::ST_START_X: state_d = gdr_pkg::ST_WAIT_X;
			gdr_pkg::ST_WAIT_X:  if (div_sts.done) state_d = gdr_pkg::ST_START_Y;
			gdr_pkg::ST_START_Y: state_d = gdr_pkg::ST_WAIT_Y;
			gdr_pkg::ST_WAIT_Y:  if (div_sts.done) state_d = gdr_pkg::ST_FIN;
			gdr_pkg::ST_FIN:     if (!out_valid_q || pad_out.ready) state_d = gdr_pkg::ST_IDLE;
			default:             state_d = gdr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pad_in.ready = 1'b0;
		div_start    = 1'b0;
		axis_y       = 1'b0;
		load_out     = 1'b0;
		case (state_q)
			gdr_pkg::ST_IDLE:    pad_in.ready = 1'b1;
			gdr_pkg::ST_START_X: div_start = 1'b1;
			gdr_pkg::ST_WAIT_X:  axis_y = 1'b0;
			gdr_pkg::ST_START_Y: begin
				div_start = 1'b1;
				axis_y    = 1'b1;
			end
			gdr_pkg::ST_WAIT_Y:  axis_y = 1'b1;
			// vertical quotient is still held by the divider here
			gdr_pkg::ST_FIN: begin
				axis_y   = 1'b1;
				load_out = !out_valid_q || pad_out.ready;
			end
			default: ;
		endcase
	end

	// poll capture; motor and trigger state move at the input transfer of a present pad
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_on_q   <= 1'b0;
			left_hold_q  <= '0;
			right_hold_q <= '0;
		end else if (in_xfer && pad_in.data.pad_present) begin
			left_hold_q  <= pad_in.data.left_trigger;
			right_hold_q <= pad_in.data.right_trigger;
			motor_on_q   <= pad_in.data.rumble_request;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			conn_q <= pad_in.data.pad_present;
			btn_q  <= gdr_pkg::remap(pad_in.data.raw_buttons, pad_in.data.left_trigger,
				pad_in.data.right_trigger);
			jx_q   <= pad_in.data.joy_x_raw;
			jy_q   <= pad_in.data.joy_y_raw;
			send_q <= pad_in.data.pad_present && pad_in.data.vibrator_present
				&& (pad_in.data.rumble_request != motor_on_q);
			if (pad_in.data.rumble_request)
				word_q <= {8'h00, gdr_pkg::MOTOR_TAG, 4'h0,
					gdr_pkg::motor_level(strength_q), gdr_pkg::MOTOR_TAG};
			else
				word_q <= '0;
		end
		if (state_q == gdr_pkg::ST_WAIT_X && div_sts.done)
			sx_q <= axis_val;
	end

	// axis operands: a = |r|, zero inside 100*a < 128*p
	assign dz    = (deadzone_q > gdr_pkg::DZ_MAX) ? gdr_pkg::DZ_MAX : deadzone_q;
	assign raw   = axis_y ? jy_q : jx_q;
	assign mag_a = raw[7] ? 8'(-raw) : 8'(raw);
	assign a100  = 14'(mag_a) * 14'd100;
	assign p128  = 14'(dz) << 7;
	assign below = a100 < p128;
	// vertical is inverted: negative result when the raw value is positive
	assign neg   = axis_y ? (!jy_q[7] && (jy_q != 8'sd0)) : jx_q[7];

	assign div_cmd.start   = div_start;
	assign div_cmd.diff    = a100 - p128;
	assign div_cmd.divisor = 7'd100 - dz;

	assign mag_e    = EXT_W'(quot);
	assign mag_neg  = (mag_e > EXT_W'(32768)) ? 16'h8000 : mag_e[15:0];

	always_comb begin
		if (below)
			axis_val = '0;
		else if (!neg)
			axis_val = (mag_e > EXT_W'(32767)) ? 16'h7FFF : mag_e[15:0];
		else
			axis_val = 16'h0000 - mag_neg;
	end

	gdr_axis_div #(
		.AXIS_FRAC_BITS(AXIS_FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (div_cmd),
		.sts   (div_sts),
		.quot  (quot)
	);

	// output register; absent pad zeroes everything but the held levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (pad_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.connected      <= conn_q;
			out_q.mapped_buttons <= conn_q ? btn_q : 16'h0000;
			out_q.stick_x        <= conn_q ? sx_q : 16'h0000;
			out_q.stick_y        <= conn_q ? axis_val : 16'h0000;
			out_q.left_level     <= left_hold_q;
			out_q.right_level    <= right_hold_q;
			out_q.motor_send     <= send_q;
			out_q.motor_word     <= send_q ? word_q : 32'h0;
		end
	end

	assign pad_out.valid = out_valid_q;
	assign pad_out.data  = out_q;

`ifndef SYNTHESIS
	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pad_in.ready |-> !div_sts.busy)
		else $error("input ready while divider busy");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == gdr_pkg::ST_START_X)
		else $error("accepted poll did not start the divider");

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pad_out.valid && !pad_out.data.connected) |->
		(pad_out.data.mapped_buttons == 16'h0 && pad_out.data.stick_x == 16'sh0
		&& pad_out.data.stick_y == 16'sh0 && !pad_out.data.motor_send))
		else $error("absent pad result not zeroed");

	a_word_needs_send: assert property (@(posedge clk) disable iff (!arst_n)
		(pad_out.valid && !pad_out.data.motor_send) |-> pad_out.data.motor_word == 32'h0)
		else $error("motor word without send");
`endif

endmodule

`default_nettype wire

// File: test/gamepad_deadzone_remapper_tb.sv
`timescale 1ns / 1ps

// Expected poll results, built from the pad state as the block should track it.
class poll_predictor;
	logic [6:0]  deadzone;
	logic [6:0]  strength;
	logic        motor_on;
	logic [7:0]  left_hold;
	logic [7:0]  right_hold;
	int          frac_bits;
	gdr_pkg::gdr_out_t due_results[$];
	int unsigned polls_taken;
	int unsigned mismatches;

	function new(int frac);
		frac_bits   = frac;
		deadzone    = 7'd15;
		strength    = 7'd100;
		motor_on    = 1'b0;
		left_hold   = '0;
		right_hold  = '0;
		polls_taken = 0;
		mismatches  = 0;
	endfunction

	function void set_reg(gdr_pkg::gdr_reg_t idx, logic [6:0] v);
		if (idx == gdr_pkg::REG_DEADZONE) begin
			deadzone = v;
		end else begin
			strength = v;
		end
	endfunction

	// axial deadzone, then rescale the remainder to full signed range
	function logic signed [15:0] scale_axis(int r);
		int     a;
		int     p;
		longint num;
		longint den;
		longint mag;
		a = (r < 0) ? -r : r;
		p = (deadzone > 7'd99) ? 99 : int'(deadzone);
		if (100 * a < 128 * p)
			return 16'sd0;
		num = longint'(100 * a - 128 * p) << frac_bits;
		den = 128 * (100 - p);
		mag = num / den;
		if (r > 0)
			return (mag > 32767) ? 16'sd32767 : 16'(mag);
		if (mag > 32768)
			mag = 32768;
		return 16'(-mag);
	endfunction

	function void take_poll(gdr_pkg::gdr_in_t p);
		gdr_pkg::gdr_out_t e;
		logic [15:0] b;
		int          s;
		int          level;
		e = '0;
		b = p.raw_buttons;
		polls_taken++;
		if (p.pad_present) begin
			left_hold  = p.left_trigger;
			right_hold = p.right_trigger;
			e.connected      = 1'b1;
			e.mapped_buttons = {b[2], b[1], p.left_trigger >= 8'd128, b[3],
				b[4], b[5], b[6], b[7], 3'b000, p.right_trigger >= 8'd128,
				1'b0, b[10], b[9], 1'b0};
			e.stick_x = scale_axis(int'(p.joy_x_raw));
			e.stick_y = scale_axis(-int'(p.joy_y_raw));
			if (p.rumble_request != motor_on) begin
				if (p.vibrator_present) begin
					e.motor_send = 1'b1;
					if (p.rumble_request) begin
						s     = (strength > 7'd100) ? 100 : int'(strength);
						level = 1 + (s * 14 + 50) / 100;
						e.motor_word = {8'h00, gdr_pkg::MOTOR_TAG, 8'(level),
							gdr_pkg::MOTOR_TAG};
					end
				end
				motor_on = p.rumble_request;
			end
		end
		e.left_level  = left_hold;
		e.right_level = right_hold;
		due_results.push_back(e);
	endfunction

	function void field_check(string fname, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			mismatches++;
			if (mismatches <= 60)
				$display("%0t %s: expected %h, got %h", $time, fname, want, seen);
		end
	endfunction

	function void match_result(gdr_pkg::gdr_out_t got);
		gdr_pkg::gdr_out_t e;
		if (due_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 60)
				$display("%0t unexpected result: expected none, got %h", $time, got);
			return;
		end
		e = due_results.pop_front();
		field_check("connected", e.connected, got.connected);
		field_check("mapped_buttons", e.mapped_buttons, got.mapped_buttons);
		field_check("stick_x", e.stick_x, got.stick_x);
		field_check("stick_y", e.stick_y, got.stick_y);
		field_check("left_level", e.left_level, got.left_level);
		field_check("right_level", e.right_level, got.right_level);
		field_check("motor_send", e.motor_send, got.motor_send);
		field_check("motor_word", e.motor_word, got.motor_word);
	endfunction
endclass

module gamepad_deadzone_remapper_tb;

	localparam int AXIS_FRAC = 15;
	// margin after the drain for any trailing results
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASE_POLLS = 140;
	localparam int LONG_HOLD = 400;

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	gdr_pkg::gdr_reg_t cfg_index;
	logic [gdr_pkg::CFG_W-1:0] cfg_wdata;

	gdr_in_if  pad_in_ch ();
	gdr_out_if pad_out_ch ();

	poll_predictor predictor;
	bit            long_hold_done;

	gamepad_deadzone_remapper #(
		.AXIS_FRAC_BITS(AXIS_FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pad_in(pad_in_ch),
		.pad_out(pad_out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Hard stop in case the block hangs; a clean run needs well under a tenth of this.
	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Result monitor: every output transfer is checked against the oldest
	// expectation. Values read here are the ones present at the edge.
	always @(posedge clk) begin
		if (arst_n && pad_out_ch.valid && pad_out_ch.ready)
			predictor.match_result(pad_out_ch.data);
	end

	// Receiver: stalls follow their own mode, chosen anew after each random-length span.
	// Once, after enough polls, it holds off for a long stretch so the block
	// fills up and has to back-pressure the sender.
	initial begin
		int mode;
		int span;
		int k;
		wait (arst_n);
		k = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 80);
			repeat (span) begin
				@(posedge clk);
				k++;
				if (!long_hold_done && predictor.polls_taken >= 150) begin
					pad_out_ch.ready <= 1'b0;
					long_hold_done = 1'b1;
					repeat (LONG_HOLD) @(posedge clk);
				end
				case (mode)
					0: begin
						pad_out_ch.ready <= 1'b1;
					end
					1: begin
						pad_out_ch.ready <= ($urandom_range(0, 3) != 0);
					end
					2: begin
						pad_out_ch.ready <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						pad_out_ch.ready <= (k % 3 != 0);
					end
				endcase
			end
		end
	end

	function automatic gdr_pkg::gdr_in_t make_poll(logic present, logic [15:0] buttons,
		logic signed [7:0] x, logic signed [7:0] y, logic [7:0] lt, logic [7:0] rt,
		logic req, logic vib);
		gdr_pkg::gdr_in_t p;
		p.pad_present      = present;
		p.raw_buttons      = buttons;
		p.joy_x_raw        = x;
		p.joy_y_raw        = y;
		p.left_trigger     = lt;
		p.right_trigger    = rt;
		p.rumble_request   = req;
		p.vibrator_present = vib;
		return p;
	endfunction

	// Stick values: a mix of plain random, the rails, and the deadzone edge
	// for the current setting.
	function automatic logic signed [7:0] pick_axis();
		int edge_mag;
		int dz;
		int v;
		dz = (predictor.deadzone > 7'd99) ? 99 : int'(predictor.deadzone);
		edge_mag = (128 * dz + 99) / 100;
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 5))
					0: v = -128;
					1: v = 127;
					2: v = -127;
					3: v = 0;
					4: v = 1;
					default: v = -1;
				endcase
			end
			1: begin
				v = edge_mag + $urandom_range(0, 2) - 1;
				if (v > 128)
					v = 128;
				if ($urandom_range(0, 1))
					v = -v;
				if (v > 127)
					v = 127;
			end
			default: v = $urandom_range(0, 255);
		endcase
		return 8'(v);
	endfunction

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd127;
			2: return 8'd128;
			3: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic gdr_pkg::gdr_in_t random_poll();
		return make_poll($urandom_range(0, 9) != 0, 16'($urandom), pick_axis(),
			pick_axis(), pick_level(), pick_level(), 1'($urandom_range(0, 1)),
			$urandom_range(0, 3) != 0);
	endfunction

	// Offer one poll and hold it until the block takes it. Returns on the
	// edge of the transfer; valid stays high for a following poll.
	task automatic offer_poll(gdr_pkg::gdr_in_t p);
		pad_in_ch.valid <= 1'b1;
		pad_in_ch.data  <= p;
		do
			@(posedge clk);
		while (!pad_in_ch.ready);
		predictor.take_poll(p);
	endtask

	// Bursts of random length, separated by random gaps (sometimes none).
	task automatic feed_polls(int count);
		int sent;
		int burst;
		int gap;
		sent = 0;
		while (sent < count) begin
			burst = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40) :
				$urandom_range(1, 8);
			for (int i = 0; i < burst && sent < count; i++) begin
				offer_poll(random_poll());
				sent++;
			end
			if (sent < count) begin
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					pad_in_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		pad_in_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (predictor.due_results.size() != 0);
	endtask

	task automatic write_reg(gdr_pkg::gdr_reg_t idx, logic [6:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		predictor.set_reg(idx, v);
		@(posedge clk);
	endtask

	initial begin
		gdr_pkg::gdr_in_t polls[$];
		logic [6:0] dz_set;
		logic [6:0] str_set;

		clk              = 1'b0;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = gdr_pkg::REG_DEADZONE;
		cfg_wdata        = '0;
		pad_in_ch.valid  = 1'b0;
		pad_in_ch.data   = '0;
		pad_out_ch.ready = 1'b0;
		long_hold_done   = 1'b0;
		predictor        = new(AXIS_FRAC);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed polls at reset settings (deadzone 15 -> edge between |r| 19 and 20).
		// absent pad right after reset: held levels still zero
		polls.push_back(make_poll(1'b0, 16'hFFFF, 8'sd127, 8'sh80, 8'd255, 8'd255,
			1'b1, 1'b1));
		// all buttons, full stick, full triggers, rumble start at full strength;
		// full negative vertical inverts and saturates
		polls.push_back(make_poll(1'b1, 16'hFFFF, 8'sd127, 8'sh80, 8'd255, 8'd255,
			1'b1, 1'b1));
		// rails the other way, triggers either side of half travel, no change
		polls.push_back(make_poll(1'b1, 16'h0000, 8'sh80, 8'sd127, 8'd127, 8'd128,
			1'b1, 1'b1));
		// pad absent: levels held, motor state kept despite request change
		polls.push_back(make_poll(1'b0, 16'h5555, 8'sh80, 8'sh80, 8'd0, 8'd0, 1'b0, 1'b1));
		// request drops with no vibration unit: state follows, no command
		polls.push_back(make_poll(1'b1, 16'hAAAA, 8'sd0, 8'sd0, 8'd128, 8'd127, 1'b0, 1'b0));
		polls.push_back(make_poll(1'b1, 16'h5555, 8'sd19, -8'sd20, 8'd0, 8'd255,
			1'b1, 1'b0));
		// stop command with unit attached: word reads zero
		polls.push_back(make_poll(1'b1, 16'h0600, -8'sd20, 8'sd19, 8'd1, 8'd0, 1'b0, 1'b1));
		polls.push_back(make_poll(1'b1, 16'h00F0, 8'sd1, -8'sd1, 8'd64, 8'd200, 1'b0, 1'b1));
		polls.push_back(make_poll(1'b1, 16'h000E, -8'sd1, 8'sd1, 8'd255, 8'd0, 1'b1, 1'b1));
		polls.push_back(make_poll(1'b1, 16'hF901, -8'sd127, 8'sd127, 8'd128, 8'd128,
			1'b1, 1'b0));
		polls.push_back(make_poll(1'b0, 16'h0000, 8'sd0, 8'sd0, 8'd255, 8'd255, 1'b0, 1'b0));
		polls.push_back(make_poll(1'b1, 16'h0000, 8'sd64, -8'sd64, 8'd0, 8'd0, 1'b0, 1'b1));
		foreach (polls[i])
			offer_poll(polls[i]);
		pad_in_ch.valid <= 1'b0;
		wait_drained();

		// Phases: the extremes first (including values past the clamp), then random.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					dz_set  = 7'd0;
					str_set = 7'd0;
				end
				1: begin
					dz_set  = 7'd99;
					str_set = 7'd100;
				end
				2: begin
					dz_set  = 7'd127;
					str_set = 7'd127;
				end
				default: begin
					dz_set  = 7'($urandom_range(0, 127));
					str_set = 7'($urandom_range(0, 127));
				end
			endcase
			write_reg(gdr_pkg::REG_DEADZONE, dz_set);
			write_reg(gdr_pkg::REG_STRENGTH, str_set);
			feed_polls(PHASE_POLLS);
			wait_drained();
		end

		// catch any stray result after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (predictor.mismatches == 0 && predictor.due_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// File: gamepad_deadzone_remapper.f
rtl/gdr_pkg.sv
rtl/gdr_if.sv
rtl/gdr_axis_div.sv
rtl/gamepad_deadzone_remapper.sv
test/gamepad_deadzone_remapper_tb.sv
